[hw/rtl/sorted_priority_queue_top_defines.svh]
// Assertion macros used by the queue checker.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue check failed");

// Check that cons holds in the cycle after ante.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

[hw/rtl/spq_pkg.sv]
package spq_pkg;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [1:0] STAT_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        push_payload;
    logic signed [15:0] push_priority;
  } spq_in_t;

  typedef struct packed {
    logic [31:0] popped_payload;
    logic        popped_valid;
    logic [1:0]  status;
    logic [31:0] head_payload;
    logic        head_valid;
    logic [4:0]  entry_count;
  } spq_out_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic push_go;
    logic pop_go;
  } spq_cell_ctl_t;

endpackage

[hw/rtl/spq_cell.sv]
module spq_cell
  import spq_pkg::*;
#(
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spq_cell_ctl_t                   ctl,
  input  logic [PAYLOAD_BITS-1:0]         new_payload,
  input  logic signed [PRIORITY_BITS-1:0] new_priority,
  input  logic                            keep_self,
  input  logic                            keep_left,
  input  logic [PAYLOAD_BITS-1:0]         left_payload,
  input  logic signed [PRIORITY_BITS-1:0] left_priority,
  input  logic                            left_used,
  input  logic [PAYLOAD_BITS-1:0]         right_payload,
  input  logic signed [PRIORITY_BITS-1:0] right_priority,
  input  logic                            right_used,
  output logic [PAYLOAD_BITS-1:0]         payload,
  output logic signed [PRIORITY_BITS-1:0] priority_val,
  output logic                            used,
  output logic                            lt_new,
  output logic                            le_new
);

  logic [PAYLOAD_BITS-1:0]         payload_r, payload_nxt;
  logic signed [PRIORITY_BITS-1:0] priority_r, priority_nxt;
  logic                            used_r, used_nxt;

  always_comb begin
    payload_nxt  = payload_r;
    priority_nxt = priority_r;
    used_nxt     = used_r;
    if (ctl.pop_go) begin
      // advance toward the head
      payload_nxt  = right_payload;
      priority_nxt = right_priority;
      used_nxt     = right_used;
    end else if (ctl.push_go && !keep_self) begin
      if (keep_left) begin
        payload_nxt  = new_payload;
        priority_nxt = new_priority;
        used_nxt     = 1'b1;
      end else begin
        // make room: take the left neighbor's entry
        payload_nxt  = left_payload;
        priority_nxt = left_priority;
        used_nxt     = left_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    payload_r  <= payload_nxt;
    priority_r <= priority_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  assign payload      = payload_r;
  assign priority_val = priority_r;
  assign used         = used_r;
  assign lt_new       = used_r && (priority_r < new_priority);
  assign le_new       = used_r && (priority_r <= new_priority);

endmodule

[hw/rtl/sorted_priority_queue_top.sv]
// Result: out_data with out_valid is registered and appears in the cycle after start is taken.
// Throughput: one request per cycle; busy stays low, since every cell compares its
// priority with the new one in the same cycle and shifts in a single step.
// Reset: synchronous active-low rst_n empties the queue (cell used bits and count
// cleared); payload and priority registers are not reset. The receiver cannot stall.
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  in_data,
  output logic     out_valid,
  output spq_out_t out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [PAYLOAD_BITS-1:0]         cell_pay  [QUEUE_DEPTH];
  logic signed [PRIORITY_BITS-1:0] cell_pri  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]          cell_used;
  logic [QUEUE_DEPTH-1:0]          cell_lt;
  logic [QUEUE_DEPTH-1:0]          cell_le;
  logic [QUEUE_DEPTH-1:0]          keep;

  logic [63:0]                     in_pay_wide;
  logic signed [31:0]              in_pri_wide;
  logic [PAYLOAD_BITS-1:0]         new_pay;
  logic signed [PRIORITY_BITS-1:0] new_pri;

  logic          accept, is_push, is_pop, full;
  spq_cell_ctl_t ctl;

  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r;
  logic [31:0]    popped_r, popped_nxt;
  logic           popped_valid_r;
  logic [1:0]     status_r, status_nxt;
  logic [63:0]    head_wide;
  logic [31:0]    count_wide;
  logic [63:0]    pop_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign in_pay_wide = 64'(in_data.push_payload);
  assign in_pri_wide = 32'(in_data.push_priority);
  assign new_pay     = in_pay_wide[PAYLOAD_BITS-1:0];
  assign new_pri     = in_pri_wide[PRIORITY_BITS-1:0];

  assign is_push     = accept && (in_data.req_type == REQ_PUSH);
  assign is_pop      = accept && (in_data.req_type == REQ_POP);
  assign full        = (count_r == CW'(QUEUE_DEPTH));
  assign ctl.push_go = is_push && !full;
  assign ctl.pop_go  = is_pop && cell_used[0];

  // A tie with the head goes in front; any later tie goes behind.
  always_comb begin
    keep[0] = cell_lt[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      keep[i] = cell_lt[0] && cell_le[i];
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [PAYLOAD_BITS-1:0]         l_pay, r_pay;
    logic signed [PRIORITY_BITS-1:0] l_pri, r_pri;
    logic                            l_used, r_used, l_keep;

    if (g == 0) begin : g_first
      assign l_pay  = '0;
      assign l_pri  = '0;
      assign l_used = 1'b0;
      assign l_keep = 1'b1;
    end else begin : g_mid
      assign l_pay  = cell_pay[g-1];
      assign l_pri  = cell_pri[g-1];
      assign l_used = cell_used[g-1];
      assign l_keep = keep[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign r_pay  = '0;
      assign r_pri  = '0;
      assign r_used = 1'b0;
    end else begin : g_inner
      assign r_pay  = cell_pay[g+1];
      assign r_pri  = cell_pri[g+1];
      assign r_used = cell_used[g+1];
    end

    spq_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .new_payload   (new_pay),
      .new_priority  (new_pri),
      .keep_self     (keep[g]),
      .keep_left     (l_keep),
      .left_payload  (l_pay),
      .left_priority (l_pri),
      .left_used     (l_used),
      .right_payload (r_pay),
      .right_priority(r_pri),
      .right_used    (r_used),
      .payload       (cell_pay[g]),
      .priority_val  (cell_pri[g]),
      .used          (cell_used[g]),
      .lt_new        (cell_lt[g]),
      .le_new        (cell_le[g])
    );
  end

  assign pop_wide = 64'(cell_pay[0]);

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    status_nxt = STAT_OK;
    if (ctl.push_go) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop_go) begin
      count_nxt  = count_r - CW'(1);
      popped_nxt = pop_wide[31:0];
    end
    if (is_push && full) begin
      status_nxt = STAT_PUSH_FULL;
    end else if (is_pop && !cell_used[0]) begin
      status_nxt = STAT_POP_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r       <= popped_nxt;
      popped_valid_r <= ctl.pop_go;
      status_r       <= status_nxt;
    end
  end

  // Head read straight from the cells and count from count_r; both already hold the beat's result.
  assign head_wide  = cell_used[0] ? 64'(cell_pay[0]) : 64'd0;
  assign count_wide = 32'(count_r);

  assign out_valid               = out_valid_r;
  assign out_data.popped_payload = popped_r;
  assign out_data.popped_valid   = popped_valid_r;
  assign out_data.status         = status_r;
  assign out_data.head_payload   = head_wide[31:0];
  assign out_data.head_valid     = cell_used[0];
  assign out_data.entry_count    = count_wide[4:0];

endmodule

[hw/rtl/spq_checker.sv]
`include "sorted_priority_queue_top_defines.svh"

module spq_checker
  import spq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input spq_in_t  in_data,
  input logic     out_valid,
  input spq_out_t out_data
);

  `SPQ_ASSERT_NEXT(a_beat_answered, clk, rst_n, start && !busy, out_valid)
  `SPQ_ASSERT_IMP(a_no_stray_result, clk, rst_n, out_valid, $past(start && !busy))
  `SPQ_ASSERT_IMP(a_head_matches_count, clk, rst_n, out_valid,
                  out_data.head_valid == (out_data.entry_count != 5'd0))
  `SPQ_ASSERT_IMP(a_pop_status, clk, rst_n, out_valid && out_data.popped_valid,
                  out_data.status == STAT_OK)
  `SPQ_ASSERT_IMP(a_empty_pop, clk, rst_n, out_valid && out_data.status == STAT_POP_EMPTY,
                  !out_data.popped_valid && out_data.entry_count == 5'd0)

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);

[bench/sorted_priority_queue_top_tb.sv]
module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int LIMIT_CYCLES = 60000;
  localparam int SETTLE_CYCLES = 5;
  // no idling while this range of beats goes through
  localparam int QUIET_FROM   = 500;
  localparam int QUIET_TO     = 850;
  localparam int MAX_REPORTS  = 60;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  spq_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  spq_out_t out_data;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_priority_queue_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  spq_in_t  pending_reqs[$];
  spq_out_t expected_resp[$];
  spq_out_t resp_want;

  logic [31:0]        held_payload  [DEPTH];
  logic signed [15:0] held_priority [DEPTH];
  int held_entries = 0;

  int reqs_queued = 0;
  int reqs_taken  = 0;
  int mismatches  = 0;
  int cycle_count = 0;

  // Sorted insert with the lopsided tie rule: equal to head goes in front,
  // equal to any later entry goes behind it.
  function automatic spq_out_t predict_response(spq_in_t req);
    spq_out_t           resp;
    int                 pos;
    logic signed [15:0] pri;
    resp = '0;
    resp.status = STAT_OK;
    pri = req.push_priority;
    if (req.req_type == REQ_PUSH) begin
      if (held_entries >= DEPTH) begin
        resp.status = STAT_PUSH_FULL;
      end else begin
        if (held_entries == 0 || pri <= held_priority[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < held_entries && held_priority[pos] <= pri) pos++;
        end
        for (int i = held_entries; i > pos; i--) begin
          held_payload[i]  = held_payload[i-1];
          held_priority[i] = held_priority[i-1];
        end
        held_payload[pos]  = req.push_payload;
        held_priority[pos] = pri;
        held_entries++;
      end
    end else if (held_entries == 0) begin
      resp.status = STAT_POP_EMPTY;
    end else begin
      resp.popped_payload = held_payload[0];
      resp.popped_valid   = 1'b1;
      for (int i = 1; i < held_entries; i++) begin
        held_payload[i-1]  = held_payload[i];
        held_priority[i-1] = held_priority[i];
      end
      held_entries--;
    end
    if (held_entries > 0) begin
      resp.head_payload = held_payload[0];
      resp.head_valid   = 1'b1;
    end
    resp.entry_count = 5'(held_entries);
    return resp;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
  endtask

  task automatic queue_req(logic kind, logic [31:0] pay, logic [15:0] pri);
    spq_in_t r;
    r.req_type      = kind;
    r.push_payload  = pay;
    r.push_priority = pri;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Wait until every beat is taken and every result is back.
  task automatic drain();
    while (reqs_taken != reqs_queued || expected_resp.size() != 0) @(posedge clk);
  endtask

  // Runs of biased push/pop mix sweep the fill level from empty to full.
  task automatic queue_random(int count);
    int          push_pct;
    int          pick;
    logic [15:0] pri;
    push_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 85;
          default: push_pct = 97;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 50) pri = 16'($signed($urandom_range(6)) - 3);
      else if (pick < 56) pri = 16'h7fff;
      else if (pick < 62) pri = 16'h8000;
      else pri = 16'($urandom());
      if ($urandom_range(99) < push_pct) queue_req(REQ_PUSH, $urandom(), pri);
      else queue_req(REQ_POP, $urandom(), 16'($urandom()));
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        expected_resp.push_back(predict_response(in_data));
        reqs_taken++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 &&
            ((reqs_taken >= QUIET_FROM && reqs_taken < QUIET_TO) ||
             $urandom_range(99) >= 6)) begin
          in_data <= pending_reqs.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_resp.size() == 0) begin
        report_mismatch("unexpected result, entry_count", 64'(out_data.entry_count), 64'd0);
      end else begin
        resp_want = expected_resp.pop_front();
        if (out_data.popped_payload !== resp_want.popped_payload)
          report_mismatch("popped_payload", 64'(out_data.popped_payload),
                          64'(resp_want.popped_payload));
        if (out_data.popped_valid !== resp_want.popped_valid)
          report_mismatch("popped_valid", 64'(out_data.popped_valid),
                          64'(resp_want.popped_valid));
        if (out_data.status !== resp_want.status)
          report_mismatch("status", 64'(out_data.status), 64'(resp_want.status));
        if (out_data.head_payload !== resp_want.head_payload)
          report_mismatch("head_payload", 64'(out_data.head_payload),
                          64'(resp_want.head_payload));
        if (out_data.head_valid !== resp_want.head_valid)
          report_mismatch("head_valid", 64'(out_data.head_valid),
                          64'(resp_want.head_valid));
        if (out_data.entry_count !== resp_want.entry_count)
          report_mismatch("entry_count", 64'(out_data.entry_count),
                          64'(resp_want.entry_count));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: pop on empty, head ties, inner ties, extremes, fill to full
    queue_req(REQ_POP, 32'h0, 16'h0);
    queue_req(REQ_PUSH, 32'haaaa_0001, 16'd0);
    queue_req(REQ_PUSH, 32'haaaa_0002, 16'd0);
    queue_req(REQ_PUSH, 32'hbbbb_0001, 16'd5);
    queue_req(REQ_PUSH, 32'hbbbb_0002, 16'd5);
    queue_req(REQ_PUSH, 32'hffff_ffff, 16'h7fff);
    queue_req(REQ_PUSH, 32'h0000_0000, 16'h8000);
    for (int i = 0; i < 10; i++)
      queue_req(REQ_PUSH, $urandom(), 16'($signed($urandom_range(20)) - 10));
    queue_req(REQ_PUSH, 32'h5555_5555, 16'h8000);
    queue_req(REQ_POP, 32'hffff_ffff, 16'hffff);
    queue_req(REQ_PUSH, 32'h1234_5678, 16'h7fff);
    queue_req(REQ_PUSH, 32'h8765_4321, 16'h0);
    for (int i = 0; i < 4; i++) queue_req(REQ_POP, 32'h0, 16'h0);
    drain();

    // hold off with the queue partly full, then go on
    queue_random(800);
    drain();
    repeat ($urandom_range(20, 5)) @(posedge clk);
    queue_random(725);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
